>>> hw/rtl/lagr_pkg.sv
// ============================================================================
// lagr_pkg - shared types and constants of the Lagrange interpolation evaluator
// Fixed-point formats, field widths, command and status codes, and the result
// bundle of the serial divider.
// ============================================================================
`default_nettype none

package lagr_pkg;

    // Node table
    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 2);

    // Item field widths
    localparam int NC_W      = 5;     // node_count register
    localparam int NI_W      = 4;     // node_index field
    localparam int STATUS_W  = 2;

    // Q16.16 arithmetic
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = Q_W + 1;           // difference of two Q16.16 values
    localparam int DVD_W     = DIFF_W + FRAC_W;   // scaled dividend magnitude
    localparam int DCNT_W    = $clog2(DVD_W);
    localparam int PROD_W    = 2 * Q_W;
    localparam int SUM_W     = Q_W + CNT_W;

    localparam logic signed [Q_W-1:0]    ONE_Q = Q_W'(1 << FRAC_W);
    localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] Q_MIN = PROD_W'(-64'sd2147483648);

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DUP = 2'd2
    } status_t;

    // Divider result bundle
    typedef struct packed {
        logic                  done;
        logic                  ovf;
        logic signed [Q_W-1:0] q;
    } div_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lagr_req_if.sv
// ============================================================================
// lagr_req_if - request item channel
// Carries one load or evaluate item with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface lagr_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [lagr_pkg::NI_W-1:0]           node_index;
    logic signed [lagr_pkg::Q_W-1:0]     node_x;
    logic signed [lagr_pkg::Q_W-1:0]     node_y;
    logic signed [lagr_pkg::Q_W-1:0]     query_x;

    modport source (output valid, cmd, node_index, node_x, node_y, query_x, input ready);
    modport sink   (input valid, cmd, node_index, node_x, node_y, query_x, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lagr_rsp_if.sv
// ============================================================================
// lagr_rsp_if - result item channel
// Carries one interpolated value and its status with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface lagr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [lagr_pkg::Q_W-1:0]     value;
    logic [lagr_pkg::STATUS_W-1:0]       status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lagr_cfg_if.sv
// ============================================================================
// lagr_cfg_if - configuration write channel
// Carries the node_count register write data with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface lagr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lagr_pkg::NC_W-1:0]           data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lagr_div.sv
// ============================================================================
// lagr_div - serial signed Q16.16 divider
// Restoring division, one quotient bit per cycle, truncated toward zero and
// clamped to the Q16.16 range with an overflow flag.
// ============================================================================
`default_nettype none

module lagr_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [lagr_pkg::DIFF_W-1:0] num,
    input  wire logic signed [lagr_pkg::DIFF_W-1:0] den,
    output lagr_pkg::div_res_t                      res
);
    import lagr_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIFF_W:0]       rem_reg, rem_next;
    logic [DVD_W-1:0]      quo_reg, quo_next;
    logic [DIFF_W-1:0]     dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;

    logic [DIFF_W-1:0]     num_mag, den_mag;
    logic [DIFF_W:0]       rem_shift;
    logic [DIFF_W+1:0]     diff;
    logic [DVD_W-1:0]      neg_quo;

    assign num_mag = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign den_mag = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

    // One restoring step: shift in the next dividend bit, try the subtract
    assign rem_shift = {rem_reg[DIFF_W-1:0], quo_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = {num_mag, {FRAC_W{1'b0}}};
            dvs_next  = den_mag;
            neg_next  = num[DIFF_W-1] ^ den[DIFF_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DIFF_W+1])
            begin
                rem_next = diff[DIFF_W:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply sign and clamp to Q16.16
    assign neg_quo = -quo_reg;

    always_comb
    begin
        res.done = done_reg;
        res.ovf  = 1'b0;
        res.q    = Q_W'(quo_reg);
        if (neg_reg)
        begin
            if (PROD_W'(quo_reg) > PROD_W'(-Q_MIN))
            begin
                res.ovf = 1'b1;
                res.q   = Q_W'(Q_MIN);
            end
            else
            begin
                res.q = Q_W'(neg_quo);
            end
        end
        else if (PROD_W'(quo_reg) > PROD_W'(Q_MAX))
        begin
            res.ovf = 1'b1;
            res.q   = Q_W'(Q_MAX);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lagrange_interpolation_evaluator_core.sv
// ============================================================================
// lagrange_interpolation_evaluator_core - Lagrange polynomial evaluator, Q16.16
// Stores up to MAX_NODES (x, y) nodes and evaluates the Lagrange polynomial
// through the first node_count of them with one shared serial divider and one
// shared 32x32 multiplier under a small sequencer.
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    cmd, node_index, node_x, node_y, query_x
//   rsp      source  valid/ready    value, status
//   cfg      sink    valid/ready    data (node_count)
//
// A load item gives no result. An evaluate item with n nodes is dominated
// by the bit-serial divide, done once for each of its n*(n-1) factors.
// req.ready is high only while the sequencer idles; loads are still taken
// while a finished result waits in the output register.
// Reset is asynchronous, active low; node_count resets to 1 and the node
// table holds garbage until loaded.
// ============================================================================
`default_nettype none

module lagrange_interpolation_evaluator_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lagr_req_if.sink   req,
    lagr_rsp_if.source rsp,
    lagr_cfg_if.sink   cfg
);
    import lagr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_JL,   // latch x_j for the repeated-node scan
        S_DUP_K,    // compare x_j against x_k
        S_EV_J,     // latch x_j, y_j, reset the running product
        S_EV_K,     // x_k available, launch the divide
        S_DIV,      // wait for the quotient
        S_MUL,      // product times quotient
        S_MSC,      // rescale product, advance k
        S_TERM,     // y_j times product
        S_TACC,     // rescale term, accumulate, advance j
        S_FIN       // clamp the sum and hand off the result
    } state_t;

    typedef struct packed {
        logic                  ovf;
        logic signed [Q_W-1:0] v;
    } scl_t;

    // Drop 16 fraction bits toward zero and clamp to Q16.16
    function automatic scl_t scale_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] t;
        scl_t                     r;
        adj   = p[PROD_W-1] ? p + PROD_W'((1 << FRAC_W) - 1) : p;
        t     = adj >>> FRAC_W;
        r.ovf = 1'b0;
        r.v   = Q_W'(t);
        if (t > Q_MAX)
        begin
            r.ovf = 1'b1;
            r.v   = Q_W'(Q_MAX);
        end
        else if (t < Q_MIN)
        begin
            r.ovf = 1'b1;
            r.v   = Q_W'(Q_MIN);
        end
        return r;
    endfunction

    // Node table
    logic signed [Q_W-1:0] abs_mem [MAX_NODES];
    logic signed [Q_W-1:0] ord_mem [MAX_NODES];
    logic signed [Q_W-1:0] rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;

    // Sequencer and datapath registers
    state_t                   state_reg, state_next;
    logic [NC_W-1:0]          node_count_reg, node_count_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic signed [Q_W-1:0]    xq_reg, xq_next;
    logic signed [Q_W-1:0]    xj_reg, xj_next;
    logic signed [Q_W-1:0]    yj_reg, yj_next;
    logic signed [Q_W-1:0]    prod_reg, prod_next;
    logic signed [Q_W-1:0]    q_reg, q_next;
    logic signed [PROD_W-1:0] mul_reg, mul_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     ovf_reg, ovf_next;
    logic                     dup_reg, dup_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]    value_reg, value_next;
    status_t                  status_reg, status_next;

    // Shared units
    logic                     div_start;
    logic signed [DIFF_W-1:0] div_num, div_den;
    div_res_t                 div_res;
    logic signed [Q_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Loop helpers
    logic [CNT_W-1:0]         n_eval, j_inc, k_inc, k_step, k_first;
    scl_t                     scl;
    logic signed [PROD_W-1:0] sum_ext;

    lagr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    assign div_num = DIFF_W'(xq_reg) - DIFF_W'(rd_x_reg);
    assign div_den = DIFF_W'(xj_reg) - DIFF_W'(rd_x_reg);

    // One multiplier: product update or final term
    assign mul_a = (state_reg == S_TERM) ? yj_reg : prod_reg;
    assign mul_b = (state_reg == S_TERM) ? prod_reg : q_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign scl     = scale_q(mul_reg);
    assign sum_ext = PROD_W'(sum_reg);

    assign n_eval  = (int'(node_count_reg) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                         : CNT_W'(node_count_reg);
    assign j_inc   = j_reg + 1'b1;
    assign k_inc   = k_reg + 1'b1;
    // Skip k == j
    assign k_step  = (k_inc == j_reg) ? k_reg + CNT_W'(2) : k_inc;
    assign k_first = (j_reg == '0) ? CNT_W'(1) : '0;

    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

    assign wr_en = req.valid && req.ready && (req.cmd == CMD_LOAD)
                   && (int'(req.node_index) < MAX_NODES);

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        xq_next         = xq_reg;
        xj_next         = xj_reg;
        yj_next         = yj_reg;
        prod_next       = prod_reg;
        q_next          = q_reg;
        mul_next        = mul_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        dup_next        = dup_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        rd_addr         = '0;
        div_start       = 1'b0;

        if (cfg.valid)
        begin
            node_count_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.cmd == CMD_EVAL)
                begin
                    xq_next  = req.query_x;
                    n_next   = n_eval;
                    j_next   = '0;
                    sum_next = '0;
                    ovf_next = 1'b0;
                    dup_next = 1'b0;
                    rd_addr  = '0;
                    // An empty node set gives zero with ok status
                    state_next = (n_eval == '0) ? S_FIN : S_DUP_JL;
                end
            end

            S_DUP_JL:
            begin
                xj_next = rd_x_reg;
                if (j_inc < n_reg)
                begin
                    k_next     = j_inc;
                    rd_addr    = j_inc[IDX_W-1:0];
                    state_next = S_DUP_K;
                end
                else
                begin
                    j_next     = '0;
                    rd_addr    = '0;
                    state_next = S_EV_J;
                end
            end

            S_DUP_K:
            begin
                if (rd_x_reg == xj_reg)
                begin
                    dup_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if (k_inc < n_reg)
                begin
                    k_next  = k_inc;
                    rd_addr = k_inc[IDX_W-1:0];
                end
                else
                begin
                    j_next     = j_inc;
                    rd_addr    = j_inc[IDX_W-1:0];
                    state_next = S_DUP_JL;
                end
            end

            S_EV_J:
            begin
                xj_next   = rd_x_reg;
                yj_next   = rd_y_reg;
                prod_next = ONE_Q;
                if (k_first < n_reg)
                begin
                    k_next     = k_first;
                    rd_addr    = k_first[IDX_W-1:0];
                    state_next = S_EV_K;
                end
                else
                begin
                    state_next = S_TERM;
                end
            end

            S_EV_K:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_res.done)
                begin
                    q_next     = div_res.q;
                    ovf_next   = ovf_reg | div_res.ovf;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                mul_next   = mul_p;
                state_next = S_MSC;
            end

            S_MSC:
            begin
                prod_next = scl.v;
                ovf_next  = ovf_reg | scl.ovf;
                if (k_step < n_reg)
                begin
                    k_next     = k_step;
                    rd_addr    = k_step[IDX_W-1:0];
                    state_next = S_EV_K;
                end
                else
                begin
                    state_next = S_TERM;
                end
            end

            S_TERM:
            begin
                mul_next   = mul_p;
                state_next = S_TACC;
            end

            S_TACC:
            begin
                sum_next = sum_reg + SUM_W'(scl.v);
                ovf_next = ovf_reg | scl.ovf;
                if (j_inc < n_reg)
                begin
                    j_next     = j_inc;
                    rd_addr    = j_inc[IDX_W-1:0];
                    state_next = S_EV_J;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (dup_reg)
                    begin
                        value_next  = '0;
                        status_next = ST_DUP;
                    end
                    else if (sum_ext > Q_MAX)
                    begin
                        value_next  = Q_W'(Q_MAX);
                        status_next = ST_OVF;
                    end
                    else if (sum_ext < Q_MIN)
                    begin
                        value_next  = Q_W'(Q_MIN);
                        status_next = ST_OVF;
                    end
                    else
                    begin
                        value_next  = Q_W'(sum_reg);
                        status_next = ovf_reg ? ST_OVF : ST_OK;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NC_W'(1);
            n_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            xq_reg         <= '0;
            xj_reg         <= '0;
            yj_reg         <= '0;
            prod_reg       <= '0;
            q_reg          <= '0;
            mul_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            n_reg          <= n_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            xq_reg         <= xq_next;
            xj_reg         <= xj_next;
            yj_reg         <= yj_next;
            prod_reg       <= prod_next;
            q_reg          <= q_next;
            mul_reg        <= mul_next;
            sum_reg        <= sum_next;
            ovf_reg        <= ovf_next;
            dup_reg        <= dup_next;
            out_valid_reg  <= out_valid_next;
            value_reg      <= value_next;
            status_reg     <= status_next;
        end
    end

    // Node memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            abs_mem[IDX_W'(req.node_index)] <= req.node_x;
            ord_mem[IDX_W'(req.node_index)] <= req.node_y;
        end
        rd_x_reg <= abs_mem[rd_addr];
        rd_y_reg <= ord_mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside the wait state");

    a_no_self_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_K) |-> (k_reg != j_reg) && (k_reg < n_reg))
        else $error("factor launched for k equal to j or beyond the node count");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final state");

    a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_DUP) |-> value_reg == '0)
        else $error("repeated-node result with nonzero value");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ============================================================================
// tb_top - testbench of the Lagrange interpolation evaluator core
// Drives load and evaluate items into the request channel and node_count
// writes into the configuration channel. A Q16.16 predictor in this file
// tracks the node table and works out each interpolated value and status.
// Every result is checked against the oldest prediction. Both channels idle
// at random, and a cycle budget built up item by item bounds the run.
// ============================================================================
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lagr_pkg::*;

    // Start no new random session once this many items have been accepted
    localparam int ITEM_TARGET   = 600;
    // Margin that lets a trailing load retire before a node_count write
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic                  cmd;
        logic [NI_W-1:0]       node_index;
        logic signed [Q_W-1:0] node_x;
        logic signed [Q_W-1:0] node_y;
        logic signed [Q_W-1:0] query_x;
    } req_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] value;
        status_t               status;
    } interp_result_t;

    logic clk;
    logic rst_n;

    lagr_req_if req_ch ();
    lagr_rsp_if rsp_ch ();
    lagr_cfg_if cfg_ch ();

    lagrange_interpolation_evaluator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the node table and of node_count
    // ------------------------------------------------------------------------
    logic signed [Q_W-1:0] abscissa_tbl [MAX_NODES];
    logic signed [Q_W-1:0] ordinate_tbl [MAX_NODES];
    logic [NC_W-1:0]       node_count_cfg;

    // Interpolated results still owed by the block, oldest first
    interp_result_t        pending_values [$];

    int     items_sent;
    int     mismatches;
    longint cycle_budget;     // estimated cycles of a correct run so far
    bit     req_steady;       // hold valid with no gaps for this stretch
    bit     rsp_steady;       // hold ready high for this stretch
    bit     clip_hit;         // set by clip_q when a value leaves Q16.16

    // ------------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Q16.16 helpers
    // ------------------------------------------------------------------------

    // Clamp to the Q16.16 range and flag any clamp for the running evaluation.
    function automatic longint clip_q(longint v);
        if (v > Q_MAX)
        begin
            clip_hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            clip_hit = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Lagrange polynomial through the first node_count stored nodes, at qx.
    // Quotients, partial products and terms all truncate toward zero and
    // saturate; a repeated abscissa wins over any overflow.
    function automatic interp_result_t lagrange_at(logic signed [Q_W-1:0] qx);
        interp_result_t res;
        int             n;
        bit             dup;
        longint         xq;
        longint         xj;
        longint         num;
        longint         den;
        longint         quot;
        longint         prod;
        longint         acc;
        n    = (node_count_cfg > MAX_NODES) ? MAX_NODES : int'(node_count_cfg);
        dup  = 1'b0;
        xq   = longint'(qx);
        acc  = 0;
        clip_hit = 1'b0;
        for (int j = 0; j < n; j++)
            for (int k = j + 1; k < n; k++)
                if (abscissa_tbl[j] == abscissa_tbl[k])
                    dup = 1'b1;
        if (dup)
        begin
            res.value  = '0;
            res.status = ST_DUP;
            return res;
        end
        for (int j = 0; j < n; j++)
        begin
            prod = longint'(ONE_Q);
            xj   = longint'(abscissa_tbl[j]);
            for (int k = 0; k < n; k++)
            begin
                if (k == j)
                    continue;
                num  = xq - longint'(abscissa_tbl[k]);
                den  = xj - longint'(abscissa_tbl[k]);
                quot = clip_q((num * longint'(ONE_Q)) / den);
                prod = clip_q((prod * quot) / longint'(ONE_Q));
            end
            acc += clip_q((longint'(ordinate_tbl[j]) * prod) / longint'(ONE_Q));
        end
        acc        = clip_q(acc);
        res.value  = acc[Q_W-1:0];
        res.status = clip_hit ? ST_OVF : ST_OK;
        return res;
    endfunction

    // Idle length: mostly short, now and then a long stretch.
    function automatic int draw_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Node abscissa: either spread on a jittered grid or anywhere in range.
    function automatic logic signed [Q_W-1:0] pick_node_x(bit wide, int base, int step,
                                                         int k);
        if (wide)
            return $urandom;
        return base + k * step + int'($urandom_range(0, step / 4));
    endfunction

    // Node ordinate: about +-16 on a grid, full range otherwise.
    function automatic logic signed [Q_W-1:0] pick_node_y(bit wide);
        if (wide)
            return $urandom;
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Present one item at the falling edge, hold it until taken, then update
    // the predictor: a load writes the table, an evaluate owes one result.
    task automatic send_item(input req_item_t it);
        int gap;
        int n;
        @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.cmd        = it.cmd;
        req_ch.node_index = it.node_index;
        req_ch.node_x     = it.node_x;
        req_ch.node_y     = it.node_y;
        req_ch.query_x    = it.query_x;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.node_index < MAX_NODES)
            begin
                abscissa_tbl[it.node_index] = it.node_x;
                ordinate_tbl[it.node_index] = it.node_y;
            end
            cycle_budget += 80;
        end
        else
        begin
            pending_values.push_back(lagrange_at(it.query_x));
            n = (node_count_cfg > MAX_NODES) ? MAX_NODES : int'(node_count_cfg);
            // one bit-serial divide per factor dominates, plus stalls
            cycle_budget += 53 * n * n + 8 * n + 80;
        end
        gap = (!req_steady && $urandom_range(0, 2) == 0) ? draw_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Load one node; the unused query field carries random bits.
    task automatic send_load(input int idx, input logic signed [Q_W-1:0] x,
                             input logic signed [Q_W-1:0] y);
        req_item_t it;
        it.cmd        = CMD_LOAD;
        it.node_index = idx[NI_W-1:0];
        it.node_x     = x;
        it.node_y     = y;
        it.query_x    = $urandom;
        send_item(it);
    endtask

    // Evaluate at qx; the unused node fields carry random bits.
    task automatic send_eval(input logic signed [Q_W-1:0] qx);
        req_item_t it;
        it.cmd        = CMD_EVAL;
        it.node_index = NI_W'($urandom);
        it.node_x     = $urandom;
        it.node_y     = $urandom;
        it.query_x    = qx;
        send_item(it);
    endtask

    // Write node_count only while the block idles: drop the request valid,
    // drain every owed result, let a trailing load retire, then write.
    task automatic write_node_count(input logic [NC_W-1:0] v);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = v;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        node_count_cfg = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = NC_W'($urandom);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------------

    // Drop ready for random stretches unless a steady stretch is running.
    initial
    begin : rsp_backpressure
        int hold;
        hold         = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && !rsp_steady && $urandom_range(0, 7) == 0)
                hold = draw_gap();
            if (hold > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold--;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // Compare every taken result with the oldest prediction, field by field.
    always @(posedge clk)
    begin : check_results
        interp_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %h status %0d",
                             rsp_ch.value, rsp_ch.status);
            end
            else
            begin
                want = pending_values.pop_front();
                if (rsp_ch.value !== want.value || rsp_ch.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: value exp %h got %h, status exp %0d got %0d",
                                 want.value, rsp_ch.value, want.status, rsp_ch.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: several times the budget of a correct run, plus slack
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        longint ticks;
        ticks = 0;
        while (ticks <= 200000 + 4 * cycle_budget)
        begin
            @(posedge clk);
            ticks++;
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // node_count is 1 after reset: the result is the one node's y, at the
    // extremes of x, y and the query point.
    task automatic test_single_node();
        send_load(0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_eval(32'sh7fff_ffff);
        send_load(0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_eval(32'sh8000_0000);
    endtask

    // Empty sum: value 0 and status ok.
    task automatic test_node_count_zero();
        write_node_count(5'd0);
        send_eval($urandom);
    endtask

    // Two nodes sharing an abscissa give a zero value and the repeat status.
    task automatic test_repeated_abscissa();
        write_node_count(5'd2);
        send_load(1, 32'sh7fff_ffff, 32'sh0001_0000);
        send_eval(32'sh0000_0000);
    endtask

    // Quotient overflow, a clean evaluation at a node, and a sum overflow
    // where every term on its own stays in range.
    task automatic test_overflow();
        send_load(0, 32'sh0000_0000, 32'sh7fff_ffff);
        send_load(1, 32'sh0000_0001, 32'sh0000_0000);
        send_eval(32'sh7fff_ffff);
        send_eval(32'sh0000_0000);
        send_load(0, 32'sh0000_0000, 32'sh8000_0000);
        send_load(1, 32'sh0002_0000, 32'sh5000_0000);
        send_eval(32'sh0003_0000);
    endtask

    // ------------------------------------------------------------------------
    // Random sessions: set node_count, load every slot in use in random
    // order, then evaluate a few times with occasional reloads in between.
    // Most sessions spread the nodes on a jittered grid so results stay
    // meaningful; some use full-range values (overflow) or force a repeat.
    // ------------------------------------------------------------------------
    task automatic test_random_sessions();
        int                    count;
        int                    n;
        int                    r;
        int                    base;
        int                    step;
        int                    evals;
        int                    idx;
        int                    a;
        int                    b;
        int                    t;
        bit                    wide;
        int                    order [MAX_NODES];
        logic signed [Q_W-1:0] plan_x [MAX_NODES];
        logic signed [Q_W-1:0] plan_y [MAX_NODES];
        logic signed [Q_W-1:0] qx;
        for (int s = 0; items_sent < ITEM_TARGET; s++)
        begin
            // open with the top of the register and the full table
            if (s == 0)
                count = 31;
            else if (s == 1)
                count = MAX_NODES;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    count = 0;
                else if (r < 60)
                    count = $urandom_range(1, 4);
                else if (r < 85)
                    count = $urandom_range(5, 8);
                else if (r < 95)
                    count = $urandom_range(9, 15);
                else
                    count = $urandom_range(16, 31);
            end
            req_steady = ($urandom_range(0, 4) == 0);
            rsp_steady = ($urandom_range(0, 4) == 0);
            write_node_count(count[NC_W-1:0]);
            n = (count > MAX_NODES) ? MAX_NODES : count;

            // plan the node set
            r    = $urandom_range(0, 99);
            wide = (r >= 70 && r < 85);
            step = $urandom_range(1 << 14, 1 << 18);
            base = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            for (int k = 0; k < n; k++)
            begin
                plan_x[k] = pick_node_x(wide, base, step, k);
                plan_y[k] = pick_node_y(wide);
                order[k]  = k;
            end
            if (r >= 85 && n >= 2)
            begin
                a = $urandom_range(0, n - 1);
                b = (a + $urandom_range(1, n - 1)) % n;
                plan_x[b] = plan_x[a];
            end

            // load every slot in use, in shuffled order
            for (int k = n - 1; k > 0; k--)
            begin
                a        = $urandom_range(0, k);
                t        = order[k];
                order[k] = order[a];
                order[a] = t;
            end
            for (int k = 0; k < n; k++)
                send_load(order[k], plan_x[order[k]], plan_y[order[k]]);

            // keep large tables to one or two evaluations; they are slow
            evals = (n >= 9) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            for (int e = 0; e < evals; e++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    idx = $urandom_range(0, MAX_NODES - 1);
                    if (idx < n)
                    begin
                        plan_x[idx] = pick_node_x(wide, base, step, idx);
                        plan_y[idx] = pick_node_y(wide);
                        send_load(idx, plan_x[idx], plan_y[idx]);
                    end
                    else
                        send_load(idx, $urandom, $urandom);
                end
                r = $urandom_range(0, 99);
                if (n == 0 || r >= 90 || wide)
                    qx = (n > 0 && r < 25) ? plan_x[$urandom_range(0, n - 1)] : $urandom;
                else if (r < 25)
                    qx = plan_x[$urandom_range(0, n - 1)];
                else
                    qx = base - step + int'($urandom_range(0, (n + 1) * step));
                send_eval(qx);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // hold every input at a known value from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_LOAD;
        req_ch.node_index = '0;
        req_ch.node_x     = '0;
        req_ch.node_y     = '0;
        req_ch.query_x    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        node_count_cfg    = 5'd1;
        items_sent        = 0;
        mismatches        = 0;
        cycle_budget      = 0;
        req_steady        = 1'b0;
        rsp_steady        = 1'b0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            abscissa_tbl[i] = '0;
            ordinate_tbl[i] = '0;
        end

        // hold reset, then release it at a falling edge, away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_node();
        test_node_count_zero();
        test_repeated_abscissa();
        test_overflow();
        test_random_sessions();

        // drain: stop sending, collect every owed result, then wait a little
        // longer so a stray extra result would still be seen
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> lagrange_interpolation_evaluator_core.f
hw/rtl/lagr_pkg.sv
hw/rtl/lagr_req_if.sv
hw/rtl/lagr_rsp_if.sv
hw/rtl/lagr_cfg_if.sv
hw/rtl/lagr_div.sv
hw/rtl/lagrange_interpolation_evaluator_core.sv
sim/tb_top.sv
